[rtl/sus_pkg.sv]
package sus_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_SPARE  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]                opcode;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic               was_present;
    logic [COUNT_W-1:0] count_after;
    logic               overflow;
  } out_item_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

[rtl/sus_cell.sv]
module sus_cell (
  input  logic                                clk,
  input  sus_pkg::cell_ctl_t                  ctl,
  input  logic signed [sus_pkg::VALUE_W-1:0]  key,
  input  logic                                valid,
  input  logic                                lt_prev,
  input  logic signed [sus_pkg::VALUE_W-1:0]  entry_prev,
  input  logic signed [sus_pkg::VALUE_W-1:0]  entry_next,
  output logic signed [sus_pkg::VALUE_W-1:0]  entry,
  output logic                                lt,
  output logic                                eq
);

  logic signed [sus_pkg::VALUE_W-1:0] entry_r, entry_nxt;
  logic                               lt_r, lt_nxt;
  logic                               eq_r, eq_nxt;

  always_comb begin
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    entry_nxt = entry_r;
    if (ctl.cmp_en) begin
      lt_nxt = valid && (entry_r < key);
      eq_nxt = valid && (entry_r == key);
    end
    if (ctl.ins && !lt_r) begin
      // boundary cell takes the new key, cells above shift up
      entry_nxt = lt_prev ? key : entry_prev;
    end else if (ctl.rem && !lt_r) begin
      entry_nxt = entry_next;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    lt_r    <= lt_nxt;
    eq_r    <= eq_nxt;
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

[rtl/sorted_unique_integer_set_unit.sv]
// Sorted set of distinct signed 32-bit values held in a row of CAPACITY cells, one
// entry per cell in ascending order. Each item passes three steps: acceptance, where
// every cell compares its entry with the value, an update step, where the row shifts
// one place up (insert) or down (remove) through neighbor links, and a result step
// that holds the result until it is taken; a new item can be accepted the cycle after.
// The update step's membership test, an OR over all cells, sets the clock limit.
// An insert of a new value into a full set is dropped and flagged as overflow.
module sorted_unique_integer_set_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sus_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sus_pkg::out_item_t out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_UPD  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]                      count_r, count_nxt;
  logic [1:0]                         op_r, op_nxt;
  logic signed [sus_pkg::VALUE_W-1:0] val_r, val_nxt;
  sus_pkg::out_item_t                 out_r, out_nxt;

  logic signed [sus_pkg::VALUE_W-1:0] key;
  logic signed [sus_pkg::VALUE_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]                lt_vec, eq_vec, valid_vec;
  sus_pkg::cell_ctl_t                 ctl;

  logic            present, full, do_ins, do_rem, do_ovf;
  logic [CW+6:0]   count_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  assign key = (state_r == S_IDLE) ? in_data.value : val_r;

  assign present = |eq_vec;
  assign full    = (count_r >= CW'(CAPACITY));
  assign do_ins  = (op_r == sus_pkg::OP_INSERT) && !present && !full;
  assign do_ovf  = (op_r == sus_pkg::OP_INSERT) && !present && full;
  assign do_rem  = (op_r == sus_pkg::OP_REMOVE) && present;

  always_comb begin
    ctl.cmp_en = in_valid && in_ready;
    ctl.ins    = (state_r == S_UPD) && do_ins;
    ctl.rem    = (state_r == S_UPD) && do_rem;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign valid_vec[gi] = (CW'(gi) < count_r);
      if (gi == 0) begin : g_first
        sus_cell u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .key        (key),
          .valid      (valid_vec[gi]),
          .lt_prev    (1'b1),
          .entry_prev (entries[gi]),
          .entry_next (entries[(gi + 1) % CAPACITY]),
          .entry      (entries[gi]),
          .lt         (lt_vec[gi]),
          .eq         (eq_vec[gi])
        );
      end else if (gi == CAPACITY - 1) begin : g_last
        sus_cell u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .key        (key),
          .valid      (valid_vec[gi]),
          .lt_prev    (lt_vec[gi-1]),
          .entry_prev (entries[gi-1]),
          .entry_next (entries[gi]),
          .entry      (entries[gi]),
          .lt         (lt_vec[gi]),
          .eq         (eq_vec[gi])
        );
      end else begin : g_mid
        sus_cell u_cell (
          .clk        (clk),
          .ctl        (ctl),
          .key        (key),
          .valid      (valid_vec[gi]),
          .lt_prev    (lt_vec[gi-1]),
          .entry_prev (entries[gi-1]),
          .entry_next (entries[gi+1]),
          .entry      (entries[gi]),
          .lt         (lt_vec[gi]),
          .eq         (eq_vec[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    out_nxt   = out_r;
    count_ext = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          val_nxt   = in_data.value;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (do_ins) begin
          count_nxt = count_r + CW'(1);
        end else if (do_rem) begin
          count_nxt = count_r - CW'(1);
        end
        count_ext           = {7'b0, count_nxt};
        out_nxt.was_present = present;
        out_nxt.count_after = count_ext[6:0];
        out_nxt.overflow    = do_ovf;
        state_nxt           = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    op_r  <= op_nxt;
    val_r <= val_nxt;
    out_r <= out_nxt;
  end

endmodule

[dv/testbench.sv]
module testbench;

  localparam int unsigned SET_DEPTH      = 64;
  localparam int unsigned ITEM_TARGET    = 2000;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  localparam logic signed [sus_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [sus_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  sus_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  sus_pkg::out_item_t out_data;

  sorted_unique_integer_set_unit #(
    .CAPACITY(SET_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the set, ascending
  logic signed [sus_pkg::VALUE_W-1:0] shadow_vals [SET_DEPTH];
  int unsigned                        shadow_count = 0;

  sus_pkg::in_item_t  pending_items[$];
  sus_pkg::out_item_t expected_results[$];
  int unsigned        mismatch_count = 0;
  int unsigned        idle_cycles = 0;
  int unsigned        tx_gap = 0;
  int unsigned        rx_stall = 0;
  bit                 no_idle = 1'b0;

  // apply one operation to the shadow set and return its result item
  function automatic sus_pkg::out_item_t set_apply(sus_pkg::in_item_t it);
    sus_pkg::out_item_t res;
    int unsigned pos;
    bit found;
    pos = 0;
    while (pos < shadow_count && shadow_vals[pos] < it.value) pos++;
    found = (pos < shadow_count) && (shadow_vals[pos] == it.value);
    res = '0;
    res.was_present = found;
    case (sus_pkg::opcode_t'(it.opcode))
      sus_pkg::OP_INSERT: begin
        if (!found) begin
          if (shadow_count >= SET_DEPTH) begin
            res.overflow = 1'b1;
          end else begin
            for (int unsigned j = shadow_count; j > pos; j--)
              shadow_vals[j] = shadow_vals[j-1];
            shadow_vals[pos] = it.value;
            shadow_count++;
          end
        end
      end
      sus_pkg::OP_REMOVE: begin
        if (found) begin
          for (int unsigned j = pos; j + 1 < shadow_count; j++)
            shadow_vals[j] = shadow_vals[j+1];
          shadow_count--;
        end
      end
      default: ;  // query and the spare code leave the set alone
    endcase
    res.count_after = sus_pkg::COUNT_W'(shadow_count);
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    logic              nxt_valid;
    sus_pkg::in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(set_apply(in_data));
        nxt_valid = 1'b0;
        tx_gap = pick_gap();
      end
      if (!nxt_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_items.size() > 0) begin
          nxt_data  = pending_items.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  // monitor
  always @(posedge clk) begin
    sus_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: was_present=%0d count_after=%0d overflow=%0d",
                     out_data.was_present, out_data.count_after, out_data.overflow);
        end else begin
          want = expected_results.pop_front();
          if (out_data.was_present !== want.was_present ||
              out_data.count_after !== want.count_after ||
              out_data.overflow    !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: expected was_present=%0d count_after=%0d ",
                        "overflow=%0d, got %0d %0d %0d"},
                       want.was_present, want.count_after, want.overflow,
                       out_data.was_present, out_data.count_after, out_data.overflow);
          end
        end
        rx_stall = pick_gap();
      end else if (rx_stall > 0) begin
        rx_stall--;
      end else if ($urandom_range(0, 7) == 0) begin
        // drop ready now and then while waiting, too
        rx_stall = pick_gap();
      end
      out_ready <= (rx_stall == 0);
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int unsigned                        queued = 0;
  logic signed [sus_pkg::VALUE_W-1:0] value_pool[$];

  task automatic queue_item(sus_pkg::opcode_t op, logic signed [sus_pkg::VALUE_W-1:0] val);
    sus_pkg::in_item_t it;
    it.opcode = op;
    it.value  = val;
    pending_items.push_back(it);
    queued++;
    if (op == sus_pkg::OP_INSERT) begin
      value_pool.push_back(val);
      if (value_pool.size() > 200) void'(value_pool.pop_front());
    end
  endtask

  // hold the sender until every expected result has come
  task automatic wait_quiet();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  function automatic logic signed [sus_pkg::VALUE_W-1:0] wide_value();
    logic signed [sus_pkg::VALUE_W-1:0] v;
    case ($urandom_range(0, 19))
      0:       v = VAL_MIN;
      1:       v = VAL_MAX;
      2:       v = 0;
      3:       v = -1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic signed [sus_pkg::VALUE_W-1:0] pool_value();
    if (value_pool.size() == 0) return wide_value();
    return value_pool[$urandom_range(0, value_pool.size() - 1)];
  endfunction

  initial begin
    int unsigned      phase;
    int unsigned      r;
    sus_pkg::opcode_t op;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, duplicates, absent values, the spare code
    queue_item(sus_pkg::OP_INSERT, 0);
    queue_item(sus_pkg::OP_INSERT, VAL_MIN);
    queue_item(sus_pkg::OP_INSERT, VAL_MAX);
    queue_item(sus_pkg::OP_INSERT, -1);
    queue_item(sus_pkg::OP_INSERT, 1);
    queue_item(sus_pkg::OP_INSERT, 0);
    queue_item(sus_pkg::OP_QUERY, VAL_MIN);
    queue_item(sus_pkg::OP_QUERY, VAL_MAX);
    queue_item(sus_pkg::OP_QUERY, 5);
    queue_item(sus_pkg::OP_SPARE, 1);
    queue_item(sus_pkg::OP_SPARE, 7);
    queue_item(sus_pkg::OP_REMOVE, 7);
    queue_item(sus_pkg::OP_REMOVE, VAL_MIN);
    queue_item(sus_pkg::OP_REMOVE, VAL_MAX);
    queue_item(sus_pkg::OP_QUERY, VAL_MIN);
    queue_item(sus_pkg::OP_REMOVE, 0);
    queue_item(sus_pkg::OP_REMOVE, -1);
    queue_item(sus_pkg::OP_REMOVE, 1);
    queue_item(sus_pkg::OP_REMOVE, 1);
    queue_item(sus_pkg::OP_QUERY, 0);
    queue_item(sus_pkg::OP_INSERT, VAL_MAX);
    queue_item(sus_pkg::OP_REMOVE, VAL_MAX);
    wait_quiet();

    phase = 0;
    while (queued < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case (phase % 4)
        0: begin
          // fill past capacity, mostly new values
          repeat (80) begin
            if ($urandom_range(0, 7) == 0) queue_item(sus_pkg::OP_QUERY, pool_value());
            else queue_item(sus_pkg::OP_INSERT, wide_value());
          end
        end
        1: begin
          // drain using values seen before
          repeat (80) begin
            r = $urandom_range(0, 9);
            if (r < 7)      queue_item(sus_pkg::OP_REMOVE, pool_value());
            else if (r < 9) queue_item(sus_pkg::OP_QUERY, pool_value());
            else            queue_item(sus_pkg::OP_REMOVE, wide_value());
          end
        end
        2: begin
          // narrow range: heavy collisions, hovers near full
          repeat (100) begin
            r = $urandom_range(0, 99);
            if (r < 50)      op = sus_pkg::OP_INSERT;
            else if (r < 80) op = sus_pkg::OP_REMOVE;
            else if (r < 95) op = sus_pkg::OP_QUERY;
            else             op = sus_pkg::OP_SPARE;
            queue_item(op, int'($urandom_range(0, 80)) - 40);
          end
        end
        default: begin
          // noise over every code and the full value range
          repeat (60) begin
            op = sus_pkg::opcode_t'($urandom_range(0, 3));
            queue_item(op, ($urandom_range(0, 1) == 0) ? wide_value() : pool_value());
          end
        end
      endcase
      if ($urandom_range(0, 2) == 0) begin
        wait_quiet();
      end else begin
        while (pending_items.size() > 20) @(negedge clk);
      end
      phase++;
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/sus_pkg.sv
rtl/sus_cell.sv
rtl/sorted_unique_integer_set_unit.sv
dv/testbench.sv
